/* rtl/hidkm_pkg.sv */
// ----------------------------------------------------------------------------
// hidkm_pkg
// Types, constants and the keycode table shared by the report decoder.
// ----------------------------------------------------------------------------
package hidkm_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned MATRIX_W    = 64;
	localparam int unsigned POS_W       = 6;
	localparam int unsigned CODE_W      = 8;
	localparam int unsigned LANE_COUNT  = 6;
	localparam int unsigned SHIFT_BIT   = 15;
	localparam int unsigned LSHIFT_MOD  = 1;

	localparam logic [CODE_W-1:0] CODE_NONE = 8'h00;

	typedef struct packed {
		logic [WORD_W-1:0] report_high;
		logic [WORD_W-1:0] report_low;
	} report_t;

	typedef struct packed {
		logic [WORD_W-1:0] matrix_high;
		logic [WORD_W-1:0] matrix_low;
	} matrix_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} key_pos_t;

	typedef logic [MATRIX_W-1:0] key_vec_t;

	function automatic key_pos_t key_lookup(input logic [CODE_W-1:0] code);
		key_pos_t r;
		r.hit = 1'b1;
		r.pos = '0;
		case (code)
			8'h04: r.pos = 6'h0a;
			8'h05: r.pos = 6'h1c;
			8'h06: r.pos = 6'h14;
			8'h07: r.pos = 6'h12;
			8'h08: r.pos = 6'h0e;
			8'h09: r.pos = 6'h15;
			8'h0a: r.pos = 6'h1a;
			8'h0b: r.pos = 6'h1d;
			8'h0c: r.pos = 6'h21;
			8'h0d: r.pos = 6'h22;
			8'h0e: r.pos = 6'h25;
			8'h0f: r.pos = 6'h2a;
			8'h10: r.pos = 6'h24;
			8'h11: r.pos = 6'h27;
			8'h12: r.pos = 6'h26;
			8'h13: r.pos = 6'h29;
			8'h14: r.pos = 6'h3e;
			8'h15: r.pos = 6'h11;
			8'h16: r.pos = 6'h0d;
			8'h17: r.pos = 6'h16;
			8'h18: r.pos = 6'h1e;
			8'h19: r.pos = 6'h1f;
			8'h1a: r.pos = 6'h09;
			8'h1b: r.pos = 6'h17;
			8'h1c: r.pos = 6'h19;
			8'h1d: r.pos = 6'h0c;
			8'h1e: r.pos = 6'h38;
			8'h1f: r.pos = 6'h3b;
			8'h20: r.pos = 6'h08;
			8'h21: r.pos = 6'h0b;
			8'h22: r.pos = 6'h10;
			8'h23: r.pos = 6'h13;
			8'h24: r.pos = 6'h18;
			8'h25: r.pos = 6'h1b;
			8'h26: r.pos = 6'h20;
			8'h27: r.pos = 6'h23;
			8'h28: r.pos = 6'h01;
			8'h2c: r.pos = 6'h3c;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/usb_hid_report_to_key_matrix.sv */
// ----------------------------------------------------------------------------
// usb_hid_report_to_key_matrix
// Boot keyboard report to 64-bit key matrix decoder.
// ----------------------------------------------------------------------------
// One report item is taken per cycle while report_stall is low, and its matrix
// item appears in the cycle after from the output register. Six keycode lanes
// decode in parallel and a merge stage ORs them with the left-shift bit into
// that single register stage, so one item per cycle passes while not stalled.
// Unknown keycodes and empty slots set no bit.
module usb_hid_report_to_key_matrix
	import hidkm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    report_valid,
	output logic    report_stall,
	input  report_t report,
	output logic    matrix_valid,
	input  logic    matrix_stall,
	output matrix_t matrix
);

	logic [LANE_COUNT-1:0][CODE_W-1:0]   codes;
	logic [LANE_COUNT-1:0][MATRIX_W-1:0] lane_bits;
	logic                                busy;

	assign codes[0] = report.report_low[23:16];
	assign codes[1] = report.report_low[31:24];
	assign codes[2] = report.report_high[7:0];
	assign codes[3] = report.report_high[15:8];
	assign codes[4] = report.report_high[23:16];
	assign codes[5] = report.report_high[31:24];

	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		hidkm_lane u_lane (
			.code    (codes[g]),
			.key_bit (lane_bits[g])
		);
	end

	hidkm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (report_valid),
		.shift_key    (report.report_low[LSHIFT_MOD]),
		.lane_bits    (lane_bits),
		.busy         (busy),
		.matrix_valid (matrix_valid),
		.matrix_stall (matrix_stall),
		.matrix       (matrix)
	);

	assign report_stall = busy;

endmodule

/* rtl/hidkm_lane.sv */
// ----------------------------------------------------------------------------
// hidkm_lane
// Decodes one keycode byte into a key matrix vector with at most one bit set.
// ----------------------------------------------------------------------------
module hidkm_lane
	import hidkm_pkg::*;
(
	input  logic [CODE_W-1:0] code,
	output key_vec_t          key_bit
);

	key_pos_t lk;

	always_comb begin
		lk = key_lookup(code);
		key_bit = '0;
		// empty slot or unknown code sets nothing
		if (lk.hit && (code != CODE_NONE)) begin
			key_bit[lk.pos] = 1'b1;
		end
	end

endmodule

/* rtl/hidkm_merge.sv */
// ----------------------------------------------------------------------------
// hidkm_merge
// ORs the lane vectors and the shift key into the registered output item.
// ----------------------------------------------------------------------------
module hidkm_merge
	import hidkm_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic                            shift_key,
	input  logic [LANE_COUNT-1:0][MATRIX_W-1:0] lane_bits,
	output logic                            busy,
	output logic                            matrix_valid,
	input  logic                            matrix_stall,
	output matrix_t                         matrix
);

	key_vec_t merged;
	logic     valid_q;
	matrix_t  matrix_q;

	always_comb begin
		merged = '0;
		merged[SHIFT_BIT] = shift_key;
		for (int i = 0; i < LANE_COUNT; i++) begin
			merged = merged | lane_bits[i];
		end
	end

	// output register frees when empty or taken this cycle
	assign busy = valid_q && matrix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!busy) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && take) begin
			matrix_q.matrix_low  <= merged[WORD_W-1:0];
			matrix_q.matrix_high <= merged[MATRIX_W-1:WORD_W];
		end
	end

	assign matrix_valid = valid_q;
	assign matrix       = matrix_q;

endmodule
